>>> rtl/i2p_pkg.sv
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_ALNUM = 3'd1;
  localparam logic [2:0] CLS_OP    = 3'd2;
  localparam logic [2:0] CLS_LPAR  = 3'd3;
  localparam logic [2:0] CLS_RPAR  = 3'd4;

  localparam logic [1:0] EMIT_CHAR  = 2'd0;
  localparam logic [1:0] EMIT_TOP   = 2'd1;
  localparam logic [1:0] EMIT_EMPTY = 2'd2;

  typedef struct packed {
    logic       in_ready;
    logic       push;
    logic       pop;
    logic       emit;
    logic [1:0] emit_sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       count_zero;
    logic       count_one;
    logic       top_lpar;
    logic       out_free;
    logic       end_flag;
    logic [2:0] cls;
  } status_t;

  function automatic logic [2:0] char_class(input logic [7:0] c);
    logic [2:0] r;
    r = CLS_NONE;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h41 && c <= 8'h5A)) begin
      r = CLS_ALNUM;
    end else if (c == CH_PLUS || c == CH_STAR || c == CH_DOT || c == CH_DOLL ||
                 c == CH_BAR) begin
      r = CLS_OP;
    end else if (c == CH_LPAR) begin
      r = CLS_LPAR;
    end else if (c == CH_RPAR) begin
      r = CLS_RPAR;
    end else if (c == CH_SPACE) begin
      r = CLS_NONE;
    end
    return r;
  endfunction

endpackage

>>> rtl/i2p_if.sv
`timescale 1ns / 1ps

interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_expr;

  modport source (output valid, output in_char, output end_of_expr, input ready);
  modport sink (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       last_of_expr;
  logic       overflow_seen;

  modport source (output valid, output out_char, output char_valid,
                  output last_of_expr, output overflow_seen, input ready);
  modport sink (input valid, input out_char, input char_valid,
                input last_of_expr, input overflow_seen, output ready);
endinterface

>>> rtl/i2p_datapath.sv
`timescale 1ns / 1ps

module i2p_datapath
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  i2p_in_if.sink    in_ch,
  i2p_out_if.source out_ch,
  input  cmd_t      cmd,
  output status_t   status
);

  logic [7:0]        mem [STACK_DEPTH];
  logic [7:0]        rd_data;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  count_m1;
  logic              full;
  logic              overflow;
  logic [7:0]        cur_char;
  logic              cur_end;
  logic              out_valid;
  logic [7:0]        out_char;
  logic              char_valid;
  logic              last_of_expr;
  logic              overflow_seen;
  logic              out_free;

  assign count_m1 = count - CNT_W'(1);
  assign full     = (count >= CNT_W'(STACK_DEPTH));
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    count_next = count;
    if (cmd.push && !full) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop && count != '0) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.push && full) begin
        overflow <= 1'b1;
      end
    end
  end

  // The top entry is read every cycle, so it is valid in the cycle after the count settles.
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[count[ADDR_W-1:0]] <= cur_char;
    end
    rd_data <= mem[count_m1[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && cmd.in_ready) begin
      cur_char <= in_ch.in_char;
      cur_end  <= in_ch.end_of_expr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_of_expr  <= cmd.last;
      overflow_seen <= overflow;
      case (cmd.emit_sel)
        EMIT_CHAR: begin
          out_char   <= cur_char;
          char_valid <= 1'b1;
        end
        EMIT_TOP: begin
          out_char   <= rd_data;
          char_valid <= 1'b1;
        end
        default: begin
          out_char   <= 8'h00;
          char_valid <= 1'b0;
        end
      endcase
    end
  end

  assign in_ch.ready          = cmd.in_ready;
  assign out_ch.valid         = out_valid;
  assign out_ch.out_char      = out_char;
  assign out_ch.char_valid    = char_valid;
  assign out_ch.last_of_expr  = last_of_expr;
  assign out_ch.overflow_seen = overflow_seen;

  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == CNT_W'(1));
  assign status.top_lpar   = (rd_data == CH_LPAR);
  assign status.out_free   = out_free;
  assign status.end_flag   = cur_end;
  assign status.cls        = char_class(cur_char);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag cleared");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result written over an untaken one");
  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop together");
`endif

endmodule

>>> rtl/i2p_ctrl.sv
`timescale 1ns / 1ps

module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_FWAIT = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       can_pop_op;

  // An operator may be popped when the stack holds something other than an open parenthesis on top.
  assign can_pop_op = !status.count_zero && !status.top_lpar;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = EMIT_CHAR;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (status.cls)
          CLS_OP: begin
            if (can_pop_op) begin
              if (status.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_TOP;
                cmd.pop      = 1'b1;
                state_next   = S_WAIT;
              end
            end else begin
              cmd.push   = 1'b1;
              state_next = S_END;
            end
          end
          CLS_RPAR: begin
            if (can_pop_op) begin
              if (status.out_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EMIT_TOP;
                cmd.pop      = 1'b1;
                state_next   = S_WAIT;
              end
            end else begin
              cmd.pop    = !status.count_zero;
              state_next = S_END;
            end
          end
          CLS_ALNUM: begin
            if (status.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_END;
            end
          end
          CLS_LPAR: begin
            cmd.push   = 1'b1;
            state_next = S_END;
          end
          default: begin
            state_next = S_END;
          end
        endcase
      end
      S_WAIT: begin
        state_next = S_EVAL;
      end
      S_END: begin
        state_next = status.end_flag ? S_FWAIT : S_IDLE;
      end
      S_FWAIT: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.count_zero) begin
            cmd.emit_sel = EMIT_EMPTY;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end else begin
            cmd.emit_sel = EMIT_TOP;
            cmd.pop      = 1'b1;
            cmd.last     = status.count_one;
            state_next   = status.count_one ? S_IDLE : S_FWAIT;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.in_ready |-> (!cmd.emit && !cmd.push && !cmd.pop))
    else $error("stack or output touched while taking input");
  a_last_flush: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("final result not followed by idle");
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    (cmd.in_ready && in_valid) |=> (state == S_EVAL))
    else $error("accepted character not evaluated");
`endif

endmodule

>>> rtl/infix_to_postfix_stack_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Fields
// in_ch     sink       in_char[7:0], end_of_expr
// out_ch    source     out_char[7:0], char_valid, last_of_expr, overflow_seen
//
// A character is taken in IDLE, evaluated in EVAL and closed in END; a popped operator
// passes WAIT back to EVAL, and a flush passes FWAIT and FLUSH for each entry flushed
// (once when empty). WAIT and FWAIT let the registered stack-top read settle after every
// change of the stack count. Reset is synchronous and clears the count, the overflow
// flag and the output register. A stalled output holds the controller in place.

module infix_to_postfix_stack_unit
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  i2p_in_if.sink    in_ch,
  i2p_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  i2p_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule

>>> tb/infix_to_postfix_stack_unit_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_stack_unit_tb
  import i2p_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_OPERAND,
    K_OPERATOR,
    K_OPEN,
    K_CLOSE
  } char_kind_e;

  typedef struct {
    logic [7:0] ch;
    logic       eoe;
  } infix_char_t;

  typedef struct {
    logic [7:0] ch;
    logic       char_valid;
    logic       last;
    logic       ovf;
  } postfix_char_t;

  logic clk;
  logic rst;

  i2p_in_if  in_ch();
  i2p_out_if out_ch();

  infix_to_postfix_stack_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  infix_char_t   infix_queue[$];
  postfix_char_t postfix_expect[$];

  // Shadow of the operator stack as the block should hold it.
  logic [7:0] shadow_stack[STACK_DEPTH];
  int         shadow_depth;
  logic       shadow_ovf;

  int mismatches;
  int cycles;
  int gap_left;
  int burst_left;
  int stall_left;
  int queued_count;

  logic [7:0] op_chars[5] = '{CH_PLUS, CH_STAR, CH_DOT, CH_DOLL, CH_BAR};

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic char_kind_e kind_of(input logic [7:0] c);
    if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      return K_OPERAND;
    end
    if (c == CH_PLUS || c == CH_STAR || c == CH_DOT || c == CH_DOLL || c == CH_BAR) begin
      return K_OPERATOR;
    end
    if (c == CH_LPAR) begin
      return K_OPEN;
    end
    if (c == CH_RPAR) begin
      return K_CLOSE;
    end
    return K_IGNORE;
  endfunction

  function automatic void emit_postfix(input logic [7:0] c, input logic v, input logic l);
    postfix_char_t r;
    r.ch         = c;
    r.char_valid = v;
    r.last       = l;
    r.ovf        = shadow_ovf;
    postfix_expect.push_back(r);
  endfunction

  function automatic void push_shadow(input logic [7:0] c);
    if (shadow_depth >= STACK_DEPTH) begin
      shadow_ovf = 1'b1;
    end else begin
      shadow_stack[shadow_depth] = c;
      shadow_depth++;
    end
  endfunction

  function automatic void pop_to_open();
    while (shadow_depth > 0 && shadow_stack[shadow_depth - 1] != CH_LPAR) begin
      shadow_depth--;
      emit_postfix(shadow_stack[shadow_depth], 1'b1, 1'b0);
    end
  endfunction

  // Works out every postfix character that one accepted infix character gives.
  function automatic void convert_char(input logic [7:0] c, input logic eoe);
    case (kind_of(c))
      K_OPERATOR: begin
        pop_to_open();
        push_shadow(c);
      end
      K_OPERAND: begin
        emit_postfix(c, 1'b1, 1'b0);
      end
      K_OPEN: begin
        push_shadow(c);
      end
      K_CLOSE: begin
        pop_to_open();
        if (shadow_depth > 0) begin
          shadow_depth--;
        end
      end
      default: begin
      end
    endcase
    if (eoe) begin
      if (shadow_depth == 0) begin
        emit_postfix(8'h00, 1'b0, 1'b1);
      end else begin
        while (shadow_depth > 0) begin
          shadow_depth--;
          emit_postfix(shadow_stack[shadow_depth], 1'b1, shadow_depth == 0);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 50) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    mismatches++;
  endtask

  function automatic void add_char(input logic [7:0] c, input logic eoe);
    infix_char_t it;
    it.ch  = c;
    it.eoe = eoe;
    infix_queue.push_back(it);
    queued_count++;
  endfunction

  function automatic logic [7:0] random_operand();
    case ($urandom_range(0, 2))
      0: return 8'("0" + $urandom_range(0, 9));
      1: return 8'("a" + $urandom_range(0, 25));
      default: return 8'("A" + $urandom_range(0, 25));
    endcase
  endfunction

  // A well-formed expression with random content, though parentheses are left
  // open now and then so that the flush has to emit them.
  function automatic void queue_expression(input int max_depth);
    infix_char_t expr[$];
    infix_char_t it;
    int          depth;
    int          len;
    bit          want_operand;
    depth        = 0;
    want_operand = 1'b1;
    it.eoe       = 1'b0;
    len          = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      if (want_operand) begin
        if (depth < max_depth && $urandom_range(0, 3) == 0) begin
          it.ch = CH_LPAR;
          depth++;
        end else begin
          it.ch        = random_operand();
          want_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        it.ch = CH_RPAR;
        depth--;
      end else begin
        it.ch        = op_chars[$urandom_range(0, 4)];
        want_operand = 1'b1;
      end
      expr.push_back(it);
      if ($urandom_range(0, 9) == 0) begin
        it.ch = CH_SPACE;
        expr.push_back(it);
      end
    end
    if (want_operand) begin
      it.ch = random_operand();
      expr.push_back(it);
    end
    while (depth > 0 && $urandom_range(0, 4) != 0) begin
      it.ch = CH_RPAR;
      expr.push_back(it);
      depth--;
    end
    if ($urandom_range(0, 3) == 0) begin
      it.ch = CH_SPACE;
    end else begin
      it = expr.pop_back();
    end
    it.eoe = 1'b1;
    expr.push_back(it);
    foreach (expr[i]) begin
      add_char(expr[i].ch, expr[i].eoe);
    end
  endfunction

  function automatic void queue_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      add_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endfunction

  function automatic void queue_random_until(input int target);
    while (queued_count < target) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_expression($urandom_range(1, 6));
      end else begin
        queue_noise();
      end
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_proc
    infix_char_t it;
    logic        hold;
    if (rst) begin
      in_ch.valid       <= 1'b0;
      in_ch.in_char     <= 8'h00;
      in_ch.end_of_expr <= 1'b0;
    end else begin
      hold = in_ch.valid && !in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        convert_char(in_ch.in_char, in_ch.end_of_expr);
      end
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (infix_queue.size() > 0) begin
          it                = infix_queue.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.in_char     <= it.ch;
          in_ch.end_of_expr <= it.eoe;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                      : $urandom_range(1, 8);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: the stall pattern follows bits 9:8 of the cycle counter.
  always @(posedge clk) begin : accept_proc
    logic rdy;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (cycles[9:8])
        2'd0: rdy = 1'b1;
        2'd1: rdy = 1'($urandom_range(0, 1));
        2'd2: rdy = (cycles % 3) != 0;
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            rdy        = 1'b0;
          end else begin
            rdy = 1'b1;
          end
        end
      endcase
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_proc
    postfix_char_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (postfix_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction, out_char %02h", out_ch.out_char));
      end else begin
        want = postfix_expect.pop_front();
        if (out_ch.out_char !== want.ch) begin
          report_mismatch($sformatf("out_char %02h, expected %02h", out_ch.out_char, want.ch));
        end
        if (out_ch.char_valid !== want.char_valid) begin
          report_mismatch($sformatf("char_valid %b, expected %b", out_ch.char_valid,
                                    want.char_valid));
        end
        if (out_ch.last_of_expr !== want.last) begin
          report_mismatch($sformatf("last_of_expr %b, expected %b", out_ch.last_of_expr,
                                    want.last));
        end
        if (out_ch.overflow_seen !== want.ovf) begin
          report_mismatch($sformatf("overflow_seen %b, expected %b", out_ch.overflow_seen,
                                    want.ovf));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("infix_to_postfix_stack_unit verification failed");
      $finish;
    end
  end

  task automatic wait_for_drain();
    @(negedge clk);
    while (infix_queue.size() > 0 || in_ch.valid || postfix_expect.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus_proc
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.in_char     = 8'h00;
    in_ch.end_of_expr = 1'b0;
    out_ch.ready      = 1'b0;
    cycles            = 0;
    mismatches        = 0;
    gap_left          = 0;
    burst_left        = 4;
    stall_left        = 0;
    queued_count      = 0;
    shadow_depth      = 0;
    shadow_ovf        = 1'b0;

    // Operand then an empty flush; ignored codes at both ends of the range.
    add_char("a", 1'b1);
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b0);
    add_char(8'h80, 1'b0);
    add_char(CH_SPACE, 1'b0);
    // A close parenthesis on an empty stack does nothing.
    add_char(CH_RPAR, 1'b0);
    // Every operator, each one popping the one before it.
    add_char("Z", 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char("9", 1'b0);
    add_char(CH_STAR, 1'b0);
    add_char("z", 1'b0);
    add_char(CH_DOT, 1'b0);
    add_char("0", 1'b0);
    add_char(CH_DOLL, 1'b0);
    add_char("A", 1'b0);
    add_char(CH_BAR, 1'b0);
    add_char(CH_LPAR, 1'b0);
    add_char(CH_LPAR, 1'b0);
    add_char("b", 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char("c", 1'b0);
    add_char(CH_RPAR, 1'b0);
    add_char(CH_RPAR, 1'b0);
    // Unmatched close: pops the operators and finds no parenthesis to drop.
    add_char(CH_PLUS, 1'b0);
    add_char(CH_RPAR, 1'b0);
    // Open parentheses left unmatched are flushed too.
    add_char(CH_LPAR, 1'b0);
    add_char(CH_LPAR, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    queue_random_until(100);
    // Hold the sender back until every expected transaction has been seen.
    wait_for_drain();
    queue_random_until(170);
    // Nest deeper than the stack so that pushes are dropped; the overflow flag
    // is sticky, so this comes late in the run.
    wait_for_drain();
    for (int i = 0; i < 18; i++) begin
      add_char(CH_LPAR, 1'b0);
      add_char(random_operand(), 1'b0);
      add_char(op_chars[$urandom_range(0, 4)], 1'b0);
    end
    add_char(random_operand(), 1'b1);
    queue_random_until(queued_count + 30);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("infix_to_postfix_stack_unit verification clean");
    end else begin
      $display("infix_to_postfix_stack_unit verification failed");
    end
    $finish;
  end

endmodule
